// File: rtl/ddo_pkg.sv
// Package for differential drive odometry: widths, constants, CORDIC angle table.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package ddo_pkg;
  localparam int unsigned CordicStepsDef = 24;
  localparam int unsigned AddrW = 4;
  localparam logic [AddrW-1:0] RegMpc  = 4'h0;
  localparam logic [AddrW-1:0] RegIwb  = 4'h4;
  localparam logic [AddrW-1:0] RegRate = 4'h8;
  localparam logic [23:0] MpcReset  = 24'd70002;
  localparam logic [30:0] IwbReset  = 31'd75915006;
  localparam logic [15:0] RateReset = 16'd250;
  localparam logic signed [31:0] PiQ28    = 32'sd843314857;
  localparam logic signed [31:0] TwoPiQ28 = 32'sd1686629713;
  localparam logic signed [63:0] PiQ30     = 64'sd3373259426;
  localparam logic signed [63:0] HalfPiQ30 = 64'sd1686629713;
  localparam logic signed [63:0] GainQ30   = 64'sd652032874;

  typedef enum logic [3:0] {
    StIdle, StMul1, StMul2, StMul3, StAtanInit, StAtanRun, StRotInit, StRotRun,
    StFinish, StOut
  } state_e;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd843314856;  5'd1: r = 32'd497837829;  5'd2: r = 32'd263043836;
      5'd3: r = 32'd133525158;  5'd4: r = 32'd67021686;   5'd5: r = 32'd33543515;
      5'd6: r = 32'd16775850;   5'd7: r = 32'd8388437;    5'd8: r = 32'd4194282;
      5'd9: r = 32'd2097149;    5'd10: r = 32'd1048575;   5'd11: r = 32'd524287;
      5'd12: r = 32'd262143;    5'd13: r = 32'd131071;    5'd14: r = 32'd65535;
      5'd15: r = 32'd32767;     5'd16: r = 32'd16383;     5'd17: r = 32'd8191;
      5'd18: r = 32'd4095;      5'd19: r = 32'd2047;      5'd20: r = 32'd1023;
      5'd21: r = 32'd511;       5'd22: r = 32'd255;       5'd23: r = 32'd127;
      5'd24: r = 32'd63;        5'd25: r = 32'd31;        5'd26: r = 32'd15;
      5'd27: r = 32'd8;         5'd28: r = 32'd4;         5'd29: r = 32'd2;
      5'd30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction
endpackage

// File: rtl/ddo_cordic.sv
// Shared CORDIC micro-rotation unit: one iteration per cycle, vectoring or rotation.
// Depends on ddo_pkg for the arctangent table.
`timescale 1ns / 1ps
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               vector_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] z_i,
  output logic               done_o,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic signed [63:0] z_o
);
  localparam int unsigned Steps = (CordicSteps < 32) ? CordicSteps : 32;
  localparam int unsigned IterW = $clog2(Steps + 1);

  logic [IterW-1:0] iter_q, iter_d;
  logic busy_q, busy_d, vec_q, vec_d;
  logic signed [63:0] x_q, x_d, y_q, y_d, z_q, z_d, xs, ys, a;
  logic [4:0] idx;
  logic up;

  assign idx = 5'(iter_q);

  always_comb begin
    xs = x_q >>> idx;
    ys = y_q >>> idx;
    a  = 64'(atan_q30(idx));
    up = vec_q ? (y_q >= 0) : (z_q < 0);
    busy_d = busy_q; vec_d = vec_q; iter_d = iter_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    if (start_i) begin
      busy_d = 1'b1; vec_d = vector_i; iter_d = '0;
      x_d = x_i; y_d = y_i; z_d = z_i;
    end else if (busy_q) begin
      if (up) begin
        x_d = x_q + ys; y_d = y_q - xs;
      end else begin
        x_d = x_q - ys; y_d = y_q + xs;
      end
      if (vec_q) z_d = (y_q >= 0) ? z_q + a : z_q - a;
      else       z_d = (z_q >= 0) ? z_q - a : z_q + a;
      iter_d = iter_q + 1'b1;
      if (iter_q == IterW'(Steps - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; vec_q <= 1'b0; iter_q <= '0;
    end else begin
      busy_q <= busy_d; vec_q <= vec_d; iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o = !busy_q && !start_i;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

// File: rtl/ddo_regs.sv
// Configuration register file behind an APB-style write/read port.
// Depends on ddo_pkg for addresses and reset values.
`timescale 1ns / 1ps
module ddo_regs
  import ddo_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [23:0]      mpc_o,
  output logic [30:0]      iwb_o,
  output logic [15:0]      rate_o
);
  logic [23:0] mpc_q;
  logic [30:0] iwb_q;
  logic [15:0] rate_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpc_q <= MpcReset; iwb_q <= IwbReset; rate_q <= RateReset;
    end else if (wr) begin
      if (paddr == RegMpc)  mpc_q  <= pwdata[23:0];
      if (paddr == RegIwb)  iwb_q  <= pwdata[30:0];
      if (paddr == RegRate) rate_q <= pwdata[15:0];
    end
  end

  always_comb begin
    case (paddr)
      RegMpc:  prdata = {8'd0, mpc_q};
      RegIwb:  prdata = {1'b0, iwb_q};
      RegRate: prdata = {16'd0, rate_q};
      default: prdata = '0;
    endcase
  end

  assign mpc_o = mpc_q;
  assign iwb_o = iwb_q;
  assign rate_o = rate_q;
endmodule

// File: rtl/differential_drive_odometry_top.sv
// Top level of differential drive odometry: sequencer, pose state, output register.
// Depends on ddo_pkg, ddo_regs and ddo_cordic.
`timescale 1ns / 1ps
// Each item goes through three multiply steps, then an atan pass and a cos/sin pass
// on the single shared CORDIC unit, one finish step, the output state and the idle
// state. A new item is accepted only in the idle state, after the last one is taken.
// in_stall_o is high from acceptance until the result item is taken. Write
// configuration over APB only while no item is in flight.
module differential_drive_odometry_top
  import ddo_pkg::*;
#(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] right_count_i,
  input  logic signed [31:0] left_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] right_speed_o,
  output logic signed [31:0] left_speed_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] angular_speed_o,
  output logic signed [31:0] x_pos_o,
  output logic signed [31:0] y_pos_o,
  output logic signed [30:0] heading_o
);
  logic [23:0] mpc;
  logic [30:0] iwb;
  logic [15:0] rate;

  ddo_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mpc_o(mpc), .iwb_o(iwb), .rate_o(rate)
  );

  state_e state_q, state_d;
  logic [31:0] last_r_q, last_l_q, px_q, py_q;
  logic signed [31:0] ph_q;
  logic signed [63:0] sr_q, sl_q, vr_q, vl_q, ratio_q, dth_q, fwd_q;
  logic flip_q;
  logic signed [31:0] rc_q, lc_q;

  logic c_start, c_vec, c_done;
  logic signed [63:0] c_xi, c_yi, c_zi, c_xo, c_yo, c_zo;

  ddo_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i, .rst_ni, .start_i(c_start), .vector_i(c_vec),
    .x_i(c_xi), .y_i(c_yi), .z_i(c_zi),
    .done_o(c_done), .x_o(c_xo), .y_o(c_yo), .z_o(c_zo)
  );

  logic signed [63:0] dr, dl, diff, rr, z0, zr, c_r, s_r, h;
  logic [63:0] mag, rmag;
  logic flip_d;
  logic load_out, acc;

  always_comb begin
    dr = 64'(signed'(rc_q - last_r_q));
    dl = -64'(signed'(lc_q - last_l_q));
    diff = sr_q - sl_q;
    mag = diff[63] ? 64'(-diff) : 64'(diff);
    rmag = (mag >> 24) * 64'(iwb) + (((mag & 64'hFFFFFF) * 64'(iwb)) >> 24);
    if (rmag > 64'h7FFFFFFF) rmag = 64'h7FFFFFFF;
    rr = diff[63] ? -$signed(rmag) : $signed(rmag);
    z0 = 64'(ph_q) * 4;
    zr = z0; flip_d = 1'b0;
    if (z0 > HalfPiQ30) begin zr = z0 - PiQ30; flip_d = 1'b1; end
    else if (z0 < -HalfPiQ30) begin zr = z0 + PiQ30; flip_d = 1'b1; end
    c_r = (c_xo + 64'sd128) >>> 8;
    s_r = (c_yo + 64'sd128) >>> 8;
    if (flip_q) begin c_r = -c_r; s_r = -s_r; end
    h = 64'(ph_q) + dth_q;
    if (h > 64'(PiQ28)) h = h - 64'(TwoPiQ28);
    if (h < -64'(PiQ28)) h = h + 64'(TwoPiQ28);
  end

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    c_start = 1'b0; c_vec = 1'b0;
    c_xi = 64'sd1 <<< 32; c_yi = ratio_q * 256; c_zi = '0;
    load_out = 1'b0;
    case (state_q)
      StIdle: if (acc) state_d = StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StMul3;
      StMul3: state_d = StAtanInit;
      StAtanInit: begin
        c_start = 1'b1; c_vec = 1'b1; state_d = StAtanRun;
      end
      StAtanRun: if (c_done) state_d = StRotInit;
      StRotInit: begin
        c_start = 1'b1;
        c_xi = ((fwd_q * GainQ30) + (64'sd1 <<< 21)) >>> 22;
        c_yi = '0; c_zi = zr;
        state_d = StRotRun;
      end
      StRotRun: if (c_done) state_d = StFinish;
      StFinish: begin load_out = 1'b1; state_d = StOut; end
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_r_q <= '0; last_l_q <= '0; px_q <= '0; py_q <= '0; ph_q <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        px_q <= px_q + c_r[31:0];
        py_q <= py_q + s_r[31:0];
        ph_q <= h[31:0];
        last_r_q <= rc_q;
        last_l_q <= lc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (acc) begin rc_q <= right_count_i; lc_q <= left_count_i; end
      StMul1: begin
        sr_q <= (dr * $signed(64'(mpc)) + 64'sd128) >>> 8;
        sl_q <= (dl * $signed(64'(mpc)) + 64'sd128) >>> 8;
      end
      StMul2: begin
        vr_q <= sat32(sr_q * 64'(rate));
        vl_q <= sat32(sl_q * 64'(rate));
        ratio_q <= rr;
        fwd_q <= sat32((sr_q + sl_q) >>> 1);
      end
      StRotInit: flip_q <= flip_d;
      default: ;
    endcase
    if (state_q == StAtanRun && c_done) dth_q <= (c_zo + 64'sd2) >>> 2;
    if (load_out) begin
      right_speed_o   <= vr_q[31:0];
      left_speed_o    <= vl_q[31:0];
      linear_speed_o  <= 32'((vr_q + vl_q) >>> 1);
      angular_speed_o <= 32'(sat32((dth_q * $signed(64'(rate)) + 64'sd8) >>> 4));
      x_pos_o <= px_q + c_r[31:0];
      y_pos_o <= py_q + s_r[31:0];
      heading_o <= h[30:0];
    end
  end

  assign out_valid_o = (state_q == StOut);
endmodule
